// ===== rtl/acirt_pkg.sv =====
package acirt_pkg;

   localparam int MainLen = 35;
   localparam int AuxLen  = 32;
   localparam int NumRegs = 7;

   typedef logic [7:0] tick_type;
   typedef logic [2:0] reg_index_type;

   // Register indexes of the configuration space.
   localparam reg_index_type RegLeaderMark  = 3'd0;
   localparam reg_index_type RegLeaderSpace = 3'd1;
   localparam reg_index_type RegBitMark     = 3'd2;
   localparam reg_index_type RegZeroSpace   = 3'd3;
   localparam reg_index_type RegOneSpace    = 3'd4;
   localparam reg_index_type RegShortGap    = 3'd5;
   localparam reg_index_type RegLongGap     = 3'd6;

   localparam tick_type LeaderMarkReset  = 8'd16;
   localparam tick_type LeaderSpaceReset = 8'd8;
   localparam tick_type BitMarkReset     = 8'd1;
   localparam tick_type ZeroSpaceReset   = 8'd1;
   localparam tick_type OneSpaceReset    = 8'd3;
   localparam tick_type ShortGapReset    = 8'd37;
   localparam tick_type LongGapReset     = 8'd73;

   localparam logic [MainLen-1:0] MainPowerOff =
      MainLen'((64'd1 << 8) | (64'd1 << 11) | (64'd1 << 21) |
               (64'd1 << 28) | (64'd1 << 30) | (64'd1 << 33));
   localparam logic [AuxLen-1:0] AuxPowerOff =
      AuxLen'((64'd1 << 13) | (64'd1 << 28) | (64'd1 << 30));

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_LEAD_MARK  = 4'd1,
      PH_LEAD_SPACE = 4'd2,
      PH_MAIN_MARK  = 4'd3,
      PH_MAIN_SPACE = 4'd4,
      PH_SGAP_MARK  = 4'd5,
      PH_SGAP_SPACE = 4'd6,
      PH_AUX_MARK   = 4'd7,
      PH_AUX_SPACE  = 4'd8,
      PH_LGAP_MARK  = 4'd9,
      PH_LGAP_SPACE = 4'd10
   } phase_type;

endpackage

// ===== rtl/ac_ir_frame_transmitter_core.sv =====
// IR remote transmitter for an air conditioner. A send command (req_type 1) taken while idle
// builds a 35-bit main frame and a 32-bit auxiliary frame and starts a transmission; every
// later tick transaction (req_type 0) moves the line through leader, main bits, short gap,
// auxiliary bits and long gap, with the segment lengths taken from the seven tick registers.
// A command that arrives while a transmission runs is ignored. Every request transaction
// yields exactly one response transaction. The block takes one request per clock cycle: the
// whole state update is a single combinational pass into the state registers and the response
// register, so the response appears in the cycle after acceptance. The response register stalls
// the request side only while a response is held and rsp_ready is low.
module ac_ir_frame_transmitter_core
   import acirt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [2:0]  req_mode,
   input  logic        req_power,
   input  logic [1:0]  req_fan_speed,
   input  logic [4:0]  req_temperature,
   input  logic [7:0]  req_timer_value,
   input  logic [8:0]  req_feature_flags,
   input  logic [1:0]  req_temp_display,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ir_level,
   output logic        rsp_busy_res,
   output logic        rsp_frame_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   tick_type               cfg_ff [NumRegs];
   logic [MainLen-1:0]     main_bits_ff, main_bits_in;
   logic [AuxLen-1:0]      aux_bits_ff, aux_bits_in;
   phase_type              phase_ff, phase_in;
   tick_type               tick_left_ff, tick_left_in;
   logic [5:0]             bit_pos_ff, bit_pos_in;
   logic                   line_out_ff, line_out_in;
   logic                   done_in;
   logic                   rsp_valid_ff;
   logic                   ir_level_ff, busy_ff, done_ff;
   logic                   req_accept;
   logic                   cfg_write;
   reg_index_type          cfg_index;
   logic [MainLen-1:0]     main_new;
   logic [AuxLen-1:0]      aux_new;
   logic [2:0]             sent_mode;
   logic [3:0]             checksum;
   logic                   active;
   logic [5:0]             bit_pos_next;

   assign pready    = 1'b1;
   assign cfg_index = reg_index_type'(paddr[4:2]);
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      prdata = 32'd0;
      if (cfg_index != reg_index_type'(NumRegs)) begin
         prdata = {24'd0, cfg_ff[cfg_index]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[RegLeaderMark]  <= LeaderMarkReset;
         cfg_ff[RegLeaderSpace] <= LeaderSpaceReset;
         cfg_ff[RegBitMark]     <= BitMarkReset;
         cfg_ff[RegZeroSpace]   <= ZeroSpaceReset;
         cfg_ff[RegOneSpace]    <= OneSpaceReset;
         cfg_ff[RegShortGap]    <= ShortGapReset;
         cfg_ff[RegLongGap]     <= LongGapReset;
      end else if (cfg_write && cfg_index != reg_index_type'(NumRegs)) begin
         cfg_ff[cfg_index] <= pwdata[7:0];
      end
   end

   // Frame assembly for a send command.
   always_comb begin
      sent_mode = (req_mode <= 3'd4) ? req_mode : 3'd0;
      checksum  = {1'b0, req_mode} + req_temperature[3:0] + 4'd4
                  + {3'd0, req_feature_flags[8]} + {3'd0, req_feature_flags[6]};
      main_new          = '0;
      main_new[2:0]     = sent_mode;
      main_new[3]       = 1'b1;
      main_new[5:4]     = req_fan_speed;
      main_new[7:6]     = req_feature_flags[1:0];
      main_new[11:8]    = req_temperature[4] ? req_temperature[3:0] : 4'd0;
      main_new[19:13]   = req_timer_value[6:0];
      main_new[24:20]   = req_feature_flags[6:2];
      main_new[28]      = 1'b1;
      main_new[30]      = 1'b1;
      main_new[33]      = 1'b1;
      aux_new           = '0;
      aux_new[0]        = req_feature_flags[7];
      aux_new[4]        = req_feature_flags[8];
      aux_new[9:8]      = req_temp_display;
      aux_new[13]       = 1'b1;
      aux_new[31:28]    = checksum;
      if (!req_power) begin
         main_new = MainPowerOff;
         aux_new  = AuxPowerOff;
      end
   end

   assign req_accept   = req_valid && req_ready;
   assign active       = (phase_ff != PH_IDLE);
   assign bit_pos_next = bit_pos_ff + 6'd1;

   // Next state for one accepted transaction.
   always_comb begin
      main_bits_in = main_bits_ff;
      aux_bits_in  = aux_bits_ff;
      phase_in     = phase_ff;
      tick_left_in = tick_left_ff;
      bit_pos_in   = bit_pos_ff;
      line_out_in  = line_out_ff;
      done_in      = 1'b0;
      if (req_type) begin
         if (!active) begin
            main_bits_in = main_new;
            aux_bits_in  = aux_new;
            bit_pos_in   = 6'd0;
            phase_in     = PH_LEAD_MARK;
            line_out_in  = 1'b0;
            tick_left_in = cfg_ff[RegLeaderMark];
         end
      end else if (active) begin
         if (tick_left_ff > 8'd1) begin
            tick_left_in = tick_left_ff - 8'd1;
         end else begin
            case (phase_ff)
               PH_LEAD_MARK: begin
                  phase_in     = PH_LEAD_SPACE;
                  line_out_in  = 1'b1;
                  tick_left_in = cfg_ff[RegLeaderSpace];
               end
               PH_LEAD_SPACE: begin
                  bit_pos_in   = 6'd0;
                  phase_in     = PH_MAIN_MARK;
                  line_out_in  = 1'b0;
                  tick_left_in = cfg_ff[RegBitMark];
               end
               PH_MAIN_MARK: begin
                  phase_in     = PH_MAIN_SPACE;
                  line_out_in  = 1'b1;
                  tick_left_in = main_bits_ff[bit_pos_ff] ? cfg_ff[RegOneSpace]
                                                          : cfg_ff[RegZeroSpace];
               end
               PH_MAIN_SPACE: begin
                  bit_pos_in   = bit_pos_next;
                  line_out_in  = 1'b0;
                  tick_left_in = cfg_ff[RegBitMark];
                  phase_in     = (bit_pos_next < 6'(MainLen)) ? PH_MAIN_MARK : PH_SGAP_MARK;
               end
               PH_SGAP_MARK: begin
                  phase_in     = PH_SGAP_SPACE;
                  line_out_in  = 1'b1;
                  tick_left_in = cfg_ff[RegShortGap];
               end
               PH_SGAP_SPACE: begin
                  bit_pos_in   = 6'd0;
                  phase_in     = PH_AUX_MARK;
                  line_out_in  = 1'b0;
                  tick_left_in = cfg_ff[RegBitMark];
               end
               PH_AUX_MARK: begin
                  phase_in     = PH_AUX_SPACE;
                  line_out_in  = 1'b1;
                  tick_left_in = aux_bits_ff[bit_pos_ff[4:0]] ? cfg_ff[RegOneSpace]
                                                              : cfg_ff[RegZeroSpace];
               end
               PH_AUX_SPACE: begin
                  bit_pos_in   = bit_pos_next;
                  line_out_in  = 1'b0;
                  tick_left_in = cfg_ff[RegBitMark];
                  phase_in     = (bit_pos_next < 6'(AuxLen)) ? PH_AUX_MARK : PH_LGAP_MARK;
               end
               PH_LGAP_MARK: begin
                  phase_in     = PH_LGAP_SPACE;
                  line_out_in  = 1'b1;
                  tick_left_in = cfg_ff[RegLongGap];
               end
               PH_LGAP_SPACE: begin
                  phase_in     = PH_IDLE;
                  line_out_in  = 1'b1;
                  tick_left_in = 8'd0;
                  done_in      = 1'b1;
               end
               default: begin
                  phase_in     = PH_IDLE;
                  tick_left_in = 8'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_left_ff <= 8'd0;
         bit_pos_ff   <= 6'd0;
         line_out_ff  <= 1'b0;
         main_bits_ff <= '0;
         aux_bits_ff  <= '0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         tick_left_ff <= tick_left_in;
         bit_pos_ff   <= bit_pos_in;
         line_out_ff  <= line_out_in;
         main_bits_ff <= main_bits_in;
         aux_bits_ff  <= aux_bits_in;
      end
   end

   // Response register.
   assign req_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ir_level_ff <= line_out_in;
         busy_ff     <= (phase_in != PH_IDLE);
         done_ff     <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ir_level   = ir_level_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_frame_done = done_ff;

endmodule

// ===== rtl/acirt_checker.sv =====
module acirt_checker
   import acirt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ir_level,
   input logic        rsp_busy_res,
   input logic        rsp_frame_done,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [4:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   // Every accepted request produces a response in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // The transaction that ends a transmission leaves the line idle with carrier off.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res && rsp_ir_level)
      else $error("frame_done seen while busy or with carrier on");

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ir_level)
         && $stable(rsp_busy_res) && $stable(rsp_frame_done))
      else $error("stalled response changed");

   // A register write reads back at once from the same address.
   a_cfg_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[4:2] != reg_index_type'(NumRegs))
      |=> (paddr[4:2] != $past(paddr[4:2])) || (prdata == {24'd0, $past(pwdata[7:0])}))
      else $error("register read back differs from the value written");

endmodule

bind ac_ir_frame_transmitter_core acirt_checker u_acirt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ir_level   (rsp_ir_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_frame_done (rsp_frame_done),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata),
   .pready         (pready)
);

// ===== tb/sv/tb_ac_ir_frame_transmitter_core.sv =====
module tb_ac_ir_frame_transmitter_core;
   import acirt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ReqTick = 1'b0;
   localparam logic ReqSend = 1'b1;

   localparam logic [2:0] ModeAuto = 3'd0;
   localparam logic [2:0] ModeCool = 3'd1;
   localparam logic [2:0] ModeFan  = 3'd3;
   localparam logic [2:0] ModeHeat = 3'd4;

   localparam int FlagSwing     = 0;
   localparam int FlagSleep     = 1;
   localparam int FlagTurbo     = 2;
   localparam int FlagVentilate = 6;
   localparam int FlagUpDown    = 7;
   localparam int FlagLeftRight = 8;

   localparam int RegUnused  = NumRegs;
   localparam int TargetItems = 1750;
   localparam int CycleLimit = 2_000_000;

   typedef struct packed {
      logic       op;
      logic [2:0] mode;
      logic       power;
      logic [1:0] fan;
      logic [4:0] temp;
      logic [7:0] timer;
      logic [8:0] flags;
      logic [1:0] disp;
   } req_item_type;

   typedef struct packed {
      logic ir_level;
      logic busy;
      logic frame_done;
   } line_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [2:0]  req_mode = '0;
   logic        req_power = 1'b0;
   logic [1:0]  req_fan_speed = '0;
   logic [4:0]  req_temperature = '0;
   logic [7:0]  req_timer_value = '0;
   logic [8:0]  req_feature_flags = '0;
   logic [1:0]  req_temp_display = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ir_level;
   logic        rsp_busy_res;
   logic        rsp_frame_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   ac_ir_frame_transmitter_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_mode          (req_mode),
      .req_power         (req_power),
      .req_fan_speed     (req_fan_speed),
      .req_temperature   (req_temperature),
      .req_timer_value   (req_timer_value),
      .req_feature_flags (req_feature_flags),
      .req_temp_display  (req_temp_display),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ir_level      (rsp_ir_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_frame_done    (rsp_frame_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Transmitter state as the block should hold it.
   tick_type           cfg_ticks [NumRegs] = '{8'd16, 8'd8, 8'd1, 8'd1, 8'd3, 8'd37, 8'd73};
   logic [MainLen-1:0] tx_main = '0;
   logic [AuxLen-1:0]  tx_aux = '0;
   phase_type          tx_phase = PH_IDLE;
   tick_type           tx_left = '0;
   int                 tx_bit = 0;
   logic               tx_line = 1'b0;

   req_item_type    pending_q[$];
   line_result_type line_results_q[$];
   req_item_type    cur_req = '0;
   bit              req_holding = 1'b0;
   bit              req_taken = 1'b0;
   int              req_wait = 0;
   bit              rsp_taken = 1'b0;
   int              rsp_stall = 0;
   int              effective_items = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   function automatic int draw_wait();
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   task automatic load_frames(input req_item_type it);
      logic [MainLen-1:0] m;
      logic [AuxLen-1:0]  a;
      logic [3:0]         csum;
      m = '0;
      a = '0;
      if (!it.power) begin
         m[8] = 1'b1;
         m[11] = 1'b1;
         m[21] = 1'b1;
         m[28] = 1'b1;
         m[30] = 1'b1;
         m[33] = 1'b1;
         a[13] = 1'b1;
         a[28] = 1'b1;
         a[30] = 1'b1;
      end else begin
         m[2:0] = (it.mode <= ModeHeat) ? it.mode : ModeAuto;
         m[3] = 1'b1;
         m[5:4] = it.fan;
         m[7:6] = it.flags[FlagSleep:FlagSwing];
         if (it.temp >= 5'd16)
            m[11:8] = it.temp[3:0];
         m[19:13] = it.timer[6:0];
         m[24:20] = it.flags[FlagVentilate:FlagTurbo];
         m[28] = 1'b1;
         m[30] = 1'b1;
         m[33] = 1'b1;
         // The checksum works on the raw mode and temperature, even out of range.
         csum = 4'(int'(it.mode) + int'(it.temp) + 4 + int'(it.flags[FlagLeftRight]) +
                   int'(it.flags[FlagVentilate]));
         a[0] = it.flags[FlagUpDown];
         a[4] = it.flags[FlagLeftRight];
         a[9:8] = it.disp;
         a[13] = 1'b1;
         a[31:28] = csum;
      end
      tx_main = m;
      tx_aux = a;
   endtask

   task automatic enter_segment(input phase_type ph, input logic lvl, input tick_type n);
      tx_phase = ph;
      tx_line = lvl;
      tx_left = n;
   endtask

   function automatic tick_type space_ticks(input logic b);
      return b ? cfg_ticks[RegOneSpace] : cfg_ticks[RegZeroSpace];
   endfunction

   task automatic next_segment(output logic done);
      done = 1'b0;
      case (tx_phase)
         PH_LEAD_MARK: enter_segment(PH_LEAD_SPACE, 1'b1, cfg_ticks[RegLeaderSpace]);
         PH_LEAD_SPACE: begin
            tx_bit = 0;
            enter_segment(PH_MAIN_MARK, 1'b0, cfg_ticks[RegBitMark]);
         end
         PH_MAIN_MARK: enter_segment(PH_MAIN_SPACE, 1'b1, space_ticks(tx_main[tx_bit]));
         PH_MAIN_SPACE: begin
            tx_bit++;
            if (tx_bit < MainLen)
               enter_segment(PH_MAIN_MARK, 1'b0, cfg_ticks[RegBitMark]);
            else
               enter_segment(PH_SGAP_MARK, 1'b0, cfg_ticks[RegBitMark]);
         end
         PH_SGAP_MARK: enter_segment(PH_SGAP_SPACE, 1'b1, cfg_ticks[RegShortGap]);
         PH_SGAP_SPACE: begin
            tx_bit = 0;
            enter_segment(PH_AUX_MARK, 1'b0, cfg_ticks[RegBitMark]);
         end
         PH_AUX_MARK: enter_segment(PH_AUX_SPACE, 1'b1, space_ticks(tx_aux[tx_bit]));
         PH_AUX_SPACE: begin
            tx_bit++;
            if (tx_bit < AuxLen)
               enter_segment(PH_AUX_MARK, 1'b0, cfg_ticks[RegBitMark]);
            else
               enter_segment(PH_LGAP_MARK, 1'b0, cfg_ticks[RegBitMark]);
         end
         PH_LGAP_MARK: enter_segment(PH_LGAP_SPACE, 1'b1, cfg_ticks[RegLongGap]);
         PH_LGAP_SPACE: begin
            enter_segment(PH_IDLE, 1'b1, '0);
            done = 1'b1;
         end
         default: begin
            tx_phase = PH_IDLE;
            tx_left = '0;
         end
      endcase
   endtask

   task automatic predict_line(input req_item_type it);
      line_result_type r;
      logic            done;
      logic            active;
      done = 1'b0;
      active = (tx_phase != PH_IDLE);
      if (it.op == ReqSend) begin
         if (!active) begin
            load_frames(it);
            tx_bit = 0;
            enter_segment(PH_LEAD_MARK, 1'b0, cfg_ticks[RegLeaderMark]);
            effective_items++;
         end
      end else if (active) begin
         effective_items++;
         if (tx_left > 8'd1)
            tx_left = tx_left - 8'd1;
         else
            next_segment(done);
      end
      r.ir_level = tx_line;
      r.busy = (tx_phase != PH_IDLE);
      r.frame_done = done;
      line_results_q.push_back(r);
   endtask

   // Request side: a transaction is taken at the rising edge, the next one is set up at the
   // falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_line(cur_req);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_holding = 1'b0;
         req_wait = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_holding = 1'b0;
            req_wait = draw_wait();
         end
         if (!req_holding) begin
            if (req_wait > 0)
               req_wait--;
            else if (pending_q.size() != 0) begin
               cur_req = pending_q.pop_front();
               req_holding = 1'b1;
            end
         end
         req_valid <= req_holding;
         req_type <= cur_req.op;
         req_mode <= cur_req.mode;
         req_power <= cur_req.power;
         req_fan_speed <= cur_req.fan;
         req_temperature <= cur_req.temp;
         req_timer_value <= cur_req.timer;
         req_feature_flags <= cur_req.flags;
         req_temp_display <= cur_req.disp;
      end
   end

   // Response side.
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (line_results_q.size() == 0) begin
            $error("response transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = line_results_q.pop_front();
            if (rsp_ir_level !== want.ir_level) begin
               $error("rsp_ir_level expected %0d actual %0d", want.ir_level, rsp_ir_level);
               mismatch_count++;
            end
            if (rsp_busy_res !== want.busy) begin
               $error("rsp_busy_res expected %0d actual %0d", want.busy, rsp_busy_res);
               mismatch_count++;
            end
            if (rsp_frame_done !== want.frame_done) begin
               $error("rsp_frame_done expected %0d actual %0d", want.frame_done,
                      rsp_frame_done);
               mismatch_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_stall = draw_wait();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_item_type random_item(input logic op);
      req_item_type it;
      it.op = op;
      it.mode = 3'($urandom_range(0, 7));
      it.power = ($urandom_range(0, 7) != 0);
      it.fan = 2'($urandom_range(0, 3));
      it.temp = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                              5'($urandom_range(16, 31));
      it.timer = 8'($urandom_range(0, 255));
      it.flags = 9'($urandom_range(0, 511));
      it.disp = 2'($urandom_range(0, 3));
      return it;
   endfunction

   task automatic push_send(input logic [2:0] mode, input logic power, input logic [1:0] fan,
                            input logic [4:0] temp, input logic [7:0] timer,
                            input logic [8:0] flags, input logic [1:0] disp);
      req_item_type it;
      it = '{op: ReqSend, mode: mode, power: power, fan: fan, temp: temp, timer: timer,
             flags: flags, disp: disp};
      pending_q.push_back(it);
   endtask

   task automatic drain_all();
      while (pending_q.size() != 0 || req_holding || line_results_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Ticks until the transmission in flight has ended and every response is in.
   task automatic finish_frame();
      drain_all();
      while (tx_phase != PH_IDLE) begin
         repeat (16) pending_q.push_back(random_item(ReqTick));
         drain_all();
      end
   endtask

   task automatic write_reg(input int idx, input tick_type val);
      logic [31:0] rd;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'(idx * 4);
      pwdata <= 32'(val);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx < NumRegs)
         cfg_ticks[idx] = val;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      psel <= 1'b1;
      paddr <= 5'(idx * 4);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (idx < NumRegs && rd !== 32'(val)) begin
         $error("prdata expected %0d actual %0d", val, rd);
         mismatch_count++;
      end
   endtask

   task automatic pick_timing();
      tick_type zs;
      tick_type os;
      zs = 8'($urandom_range(0, 3));
      os = 8'($urandom_range(0, 5));
      // A zero register behaves as one tick, so keep the two bit spaces apart.
      if (os == zs || (zs <= 8'd1 && os <= 8'd1))
         os = zs + 8'd2;
      write_reg(RegLeaderMark, 8'($urandom_range(0, 6)));
      write_reg(RegLeaderSpace, 8'($urandom_range(0, 6)));
      write_reg(RegBitMark, 8'($urandom_range(0, 3)));
      write_reg(RegZeroSpace, zs);
      write_reg(RegOneSpace, os);
      write_reg(RegShortGap, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                                          8'($urandom_range(0, 12)));
      write_reg(RegLongGap, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                                         8'($urandom_range(0, 12)));
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: a tick while idle, a command, and a command while busy.
      pending_q.push_back(random_item(ReqTick));
      push_send(ModeCool, 1'b1, 2'd2, 5'd24, 8'h15, 9'h0A5, 2'd1);
      push_send(ModeHeat, 1'b1, 2'd1, 5'd18, 8'h00, 9'h000, 2'd0);
      finish_frame();

      // Shortest segments; a write past the last register must not land anywhere.
      write_reg(RegLeaderMark, 8'd1);
      write_reg(RegLeaderSpace, 8'd1);
      write_reg(RegBitMark, 8'd1);
      write_reg(RegZeroSpace, 8'd1);
      write_reg(RegOneSpace, 8'd2);
      write_reg(RegShortGap, 8'd1);
      write_reg(RegLongGap, 8'd1);
      write_reg(RegUnused, 8'hFF);
      push_send(3'd7, 1'b1, 2'd3, 5'd31, 8'hFF, 9'h1FF, 2'd3);
      finish_frame();
      push_send(ModeFan, 1'b1, 2'd2, 5'd15, 8'h7F, 9'h100, 2'd1);
      finish_frame();
      push_send(ModeCool, 1'b0, 2'd3, 5'd25, 8'hC9, 9'h1E7, 2'd3);
      finish_frame();

      // Zero in a register lasts one tick, as does a one; the long gap runs at full count.
      for (int i = 0; i < NumRegs; i++)
         write_reg(i, (i == RegOneSpace) ? 8'd2 : ((i == RegLongGap) ? 8'd255 : 8'd0));
      pending_q.push_back(random_item(ReqSend));
      finish_frame();

      while (effective_items < TargetItems) begin
         pick_timing();
         repeat (2) begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 5)) pending_q.push_back(random_item(ReqTick));
            pending_q.push_back(random_item(ReqSend));
            n = $urandom_range(50, 300);
            repeat (n) begin
               if ($urandom_range(0, 19) == 0)
                  pending_q.push_back(random_item(ReqSend));
               else
                  pending_q.push_back(random_item(ReqTick));
            end
            finish_frame();
         end
      end

      drain_all();
      repeat (16) @(posedge clock);
      if (line_results_q.size() != 0) begin
         $error("%0d response transactions never arrived", line_results_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== ac_ir_frame_transmitter_core.f =====
rtl/acirt_pkg.sv
rtl/ac_ir_frame_transmitter_core.sv
rtl/acirt_checker.sv
tb/sv/tb_ac_ir_frame_transmitter_core.sv
